### rtl/core/lere_pkg.sv
// ---------------------------------------------------------------------------
// lere_pkg
// Shared types and constants of the line-editing read engine.
// ---------------------------------------------------------------------------
package lere_pkg;

  // Address arithmetic width; sums of buffer addresses wrap at this width.
  localparam int ADDR_WIDTH = 32;
  localparam int SUM_W      = (ADDR_WIDTH > 32) ? ADDR_WIDTH : 32;

  localparam int MAX_RESULTS = 4;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W       = $clog2(MAX_RESULTS);
  localparam int CFG_IDX_W   = 2;

  // Result kinds
  localparam logic [2:0] KIND_ECHO    = 3'd0;
  localparam logic [2:0] KIND_STORE   = 3'd1;
  localparam logic [2:0] KIND_DONE    = 3'd2;
  localparam logic [2:0] KIND_BADFD   = 3'd3;
  localparam logic [2:0] KIND_BADADDR = 3'd4;

  // Input operations
  localparam logic OP_START = 1'b0;
  localparam logic OP_CHAR  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUEST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_LOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_HIGH   = 2'd3;

  localparam logic [31:0] RST_MAX_REQUEST = 32'h0400_0000;
  localparam logic [31:0] RST_HEAP_BASE   = 32'ha000_0000;
  localparam logic [31:0] RST_FREE_LOW    = 32'ha3ed_f000;
  localparam logic [31:0] RST_FREE_HIGH   = 32'ha3ef_ffff;

  // Character codes
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_DEL = 8'h7f;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_NL  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;

  typedef struct packed {
    logic        op;
    logic [9:0]  descriptor;
    logic [31:0] buf_addr;
    logic [31:0] req_count;
    logic [31:0] stack_top;
    logic [7:0]  rx_char;
  } item_t;

  typedef struct packed {
    logic [31:0] max_request;
    logic [31:0] heap_base;
    logic [31:0] free_low;
    logic [31:0] free_high;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_char;
    logic [31:0] out_addr;
    logic [31:0] length;
  } res_t;

  typedef struct packed {
    res_t [MAX_RESULTS-1:0] slot;
    logic [CNT_W-1:0]       count;
  } grp_t;

endpackage

### rtl/core/lere_if.sv
// ---------------------------------------------------------------------------
// lere_if
// Channel interfaces: request input, result output, configuration writes.
// ---------------------------------------------------------------------------
interface lere_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [9:0]  descriptor;
  logic [31:0] buf_addr;
  logic [31:0] req_count;
  logic [31:0] stack_top;
  logic [7:0]  rx_char;

  modport source (output valid, op, descriptor, buf_addr, req_count, stack_top, rx_char,
                  input ready);
  modport sink   (input valid, op, descriptor, buf_addr, req_count, stack_top, rx_char,
                  output ready);
endinterface

interface lere_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_char;
  logic [31:0] out_addr;
  logic [31:0] length;
  logic        last;

  modport source (output valid, kind, out_char, out_addr, length, last, input ready);
  modport sink   (input valid, kind, out_char, out_addr, length, last, output ready);
endinterface

interface lere_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lere_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/lere_cfg_regs.sv
// ---------------------------------------------------------------------------
// lere_cfg_regs
// Configuration register file: request size limit and permitted regions.
// ---------------------------------------------------------------------------
module lere_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  lere_cfg_if.sink       cfg,
  output lere_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_request <= lere_pkg::RST_MAX_REQUEST;
      regs.heap_base   <= lere_pkg::RST_HEAP_BASE;
      regs.free_low    <= lere_pkg::RST_FREE_LOW;
      regs.free_high   <= lere_pkg::RST_FREE_HIGH;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        lere_pkg::CFG_MAX_REQUEST: regs.max_request <= cfg.data;
        lere_pkg::CFG_HEAP_BASE:   regs.heap_base   <= cfg.data;
        lere_pkg::CFG_FREE_LOW:    regs.free_low    <= cfg.data;
        lere_pkg::CFG_FREE_HIGH:   regs.free_high   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/lere_step.sv
// ---------------------------------------------------------------------------
// lere_step
// Read state and per-item decode: request checks, line editing, result group.
// ---------------------------------------------------------------------------
module lere_step (
  input  logic            clk,
  input  logic            rst,
  input  lere_pkg::cfg_t  cfg,
  input  lere_pkg::item_t item,
  input  logic            fire,
  output lere_pkg::grp_t  grp
);

  typedef logic [lere_pkg::ADDR_WIDTH-1:0] addr_t;
  typedef logic [lere_pkg::SUM_W-1:0]      wide_t;

  logic        active, active_next;
  logic [31:0] fill_count, fill_count_next;
  logic [31:0] base_address, base_address_next;
  logic [31:0] limit_count, limit_count_next;

  addr_t       end_addr;
  logic        ok_heap, ok_free, room;
  logic [31:0] store_idx;
  addr_t       store_sum;
  logic [31:0] store_addr;

  function automatic lere_pkg::res_t mk_res(logic [2:0] kind, logic [7:0] ch,
                                            logic [31:0] addr, logic [31:0] len);
    lere_pkg::res_t r;
    r.kind     = kind;
    r.out_char = ch;
    r.out_addr = addr;
    r.length   = len;
    return r;
  endfunction

  // Start request window check, wrapping at the address width
  assign end_addr = addr_t'(item.buf_addr) + addr_t'(item.req_count);
  assign ok_heap  = (wide_t'(end_addr) < wide_t'(item.stack_top)) &&
                    (item.buf_addr >= cfg.heap_base);
  assign ok_free  = (wide_t'(end_addr) <= wide_t'(cfg.free_high)) &&
                    (item.buf_addr >= cfg.free_low);

  assign room       = fill_count < limit_count;
  // Delete (DEL) rewrites the last filled byte, everything else the next one
  assign store_idx  = (item.rx_char == lere_pkg::CH_DEL) ? fill_count - 32'd1 : fill_count;
  assign store_sum  = addr_t'(base_address) + addr_t'(store_idx);
  assign store_addr = 32'(store_sum);

  always_comb begin
    active_next       = active;
    fill_count_next   = fill_count;
    base_address_next = base_address;
    limit_count_next  = limit_count;
    grp               = '0;

    if (item.op == lere_pkg::OP_START) begin
      active_next = 1'b0;
      if (item.descriptor != 10'd0) begin
        grp.slot[0] = mk_res(lere_pkg::KIND_BADFD, 8'd0, 32'd0, 32'd0);
        grp.count   = lere_pkg::CNT_W'(1);
      end else if ((item.req_count > cfg.max_request) || !(ok_heap || ok_free)) begin
        grp.slot[0] = mk_res(lere_pkg::KIND_BADADDR, 8'd0, 32'd0, 32'd0);
        grp.count   = lere_pkg::CNT_W'(1);
      end else begin
        active_next       = 1'b1;
        fill_count_next   = 32'd0;
        base_address_next = item.buf_addr;
        limit_count_next  = item.req_count;
      end
    end else if (active) begin
      if (item.rx_char == lere_pkg::CH_EOT) begin
        active_next = 1'b0;
        grp.slot[0] = mk_res(lere_pkg::KIND_DONE, 8'd0, 32'd0, fill_count);
        grp.count   = lere_pkg::CNT_W'(1);
      end else if (item.rx_char == lere_pkg::CH_DEL) begin
        if (fill_count != 32'd0) begin
          fill_count_next = fill_count - 32'd1;
          grp.slot[0] = mk_res(lere_pkg::KIND_STORE, 8'd0, store_addr, 32'd0);
          grp.slot[1] = mk_res(lere_pkg::KIND_ECHO, lere_pkg::CH_BS, 32'd0, 32'd0);
          grp.slot[2] = mk_res(lere_pkg::KIND_ECHO, lere_pkg::CH_SP, 32'd0, 32'd0);
          grp.slot[3] = mk_res(lere_pkg::KIND_ECHO, lere_pkg::CH_BS, 32'd0, 32'd0);
          grp.count   = lere_pkg::CNT_W'(4);
        end
      end else if (item.rx_char == lere_pkg::CH_NL || item.rx_char == lere_pkg::CH_CR) begin
        active_next = 1'b0;
        if (room) begin
          fill_count_next = fill_count + 32'd1;
          grp.slot[0] = mk_res(lere_pkg::KIND_STORE, lere_pkg::CH_NL, store_addr, 32'd0);
          grp.slot[1] = mk_res(lere_pkg::KIND_ECHO, lere_pkg::CH_NL, 32'd0, 32'd0);
          grp.slot[2] = mk_res(lere_pkg::KIND_DONE, 8'd0, 32'd0, fill_count + 32'd1);
          grp.count   = lere_pkg::CNT_W'(3);
        end else begin
          grp.slot[0] = mk_res(lere_pkg::KIND_DONE, 8'd0, 32'd0, fill_count);
          grp.count   = lere_pkg::CNT_W'(1);
        end
      end else begin
        if (room) begin
          fill_count_next = fill_count + 32'd1;
          grp.slot[0] = mk_res(lere_pkg::KIND_STORE, item.rx_char, store_addr, 32'd0);
          grp.slot[1] = mk_res(lere_pkg::KIND_ECHO, item.rx_char, 32'd0, 32'd0);
          grp.count   = lere_pkg::CNT_W'(2);
        end else begin
          active_next = 1'b0;
          grp.slot[0] = mk_res(lere_pkg::KIND_DONE, 8'd0, 32'd0, fill_count);
          grp.count   = lere_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      fill_count   <= 32'd0;
      base_address <= 32'd0;
      limit_count  <= 32'd0;
    end else if (fire) begin
      active       <= active_next;
      fill_count   <= fill_count_next;
      base_address <= base_address_next;
      limit_count  <= limit_count_next;
    end
  end

  // A rejected start never leaves a read open
  a_reject_closes: assert property (@(posedge clk) disable iff (rst)
    fire && item.op == lere_pkg::OP_START && grp.count != '0 |=> !active)
    else $error("read left open after rejected start");

  // Fill never passes the request limit
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    active |-> fill_count <= limit_count)
    else $error("fill count beyond limit");

endmodule

### rtl/core/lere_out_group.sv
// ---------------------------------------------------------------------------
// lere_out_group
// Result group register; hands out the results of one item, one per cycle while res is ready.
// ---------------------------------------------------------------------------
module lere_out_group (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  lere_pkg::grp_t grp_in,
  output logic           free,
  lere_out_if.source     res
);

  lere_pkg::res_t [lere_pkg::MAX_RESULTS-1:0] slot;
  logic [lere_pkg::CNT_W-1:0] count;
  logic [lere_pkg::IDX_W-1:0] idx;
  logic                       take;
  lere_pkg::res_t             cur;

  assign cur          = slot[idx];
  assign res.valid    = count != '0;
  assign res.kind     = cur.kind;
  assign res.out_char = cur.out_char;
  assign res.out_addr = cur.out_addr;
  assign res.length   = cur.length;
  assign res.last     = (lere_pkg::CNT_W'(idx) + lere_pkg::CNT_W'(1)) == count;

  assign take = res.valid && res.ready;
  assign free = (count == '0) || (take && res.last);

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= grp_in.slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else if (load) begin
      count <= grp_in.count;
      idx   <= '0;
    end else if (take) begin
      if (res.last) begin
        count <= '0;
        idx   <= '0;
      end else begin
        idx <= idx + lere_pkg::IDX_W'(1);
      end
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("group overwritten before its last result left");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> lere_pkg::CNT_W'(idx) < count)
    else $error("result index beyond group count");

  a_group_continues: assert property (@(posedge clk) disable iff (rst)
    take && !res.last |=> res.valid && idx == $past(idx) + lere_pkg::IDX_W'(1))
    else $error("group ended before its last result");

endmodule

### rtl/core/line_edit_read_engine.sv
// ---------------------------------------------------------------------------
// line_edit_read_engine
// Terminal line-input read engine: request checks, line editing and echo.
//
//   channel  dir  payload                                           ready
//   req      in   op, descriptor, buf_addr, req_count, stack_top,   input register
//                 rx_char
//   res      out  kind, out_char, out_addr, length, last            result group
//   cfg      in   index, data                                       always 1
//
// An item waits in the input register; its whole result group (zero to four
// results) is computed, and a non-empty group is loaded into the group
// register once it is free. The group register hands out one result per
// cycle while res is ready; an item with no results passes straight through.
// Reset (rst, synchronous) closes any read and restores the register defaults.
// A stall on res holds the current result; req backs up after one item.
// ---------------------------------------------------------------------------
module line_edit_read_engine (
  input  logic       clk,
  input  logic       rst,
  lere_in_if.sink    req,
  lere_out_if.source res,
  lere_cfg_if.sink   cfg
);

  lere_pkg::cfg_t  regs;
  lere_pkg::item_t item;
  lere_pkg::grp_t  grp;
  logic            ivalid;
  logic            move;
  logic            group_free;

  lere_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  lere_step u_step (
    .clk  (clk),
    .rst  (rst),
    .cfg  (regs),
    .item (item),
    .fire (move),
    .grp  (grp)
  );

  lere_out_group u_group (
    .clk    (clk),
    .rst    (rst),
    .load   (move && grp.count != '0),
    .grp_in (grp),
    .free   (group_free),
    .res    (res)
  );

  // Items with no result pass straight through the decode
  assign move      = ivalid && ((grp.count == '0) || group_free);
  assign req.ready = !ivalid || move;

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.op         <= req.op;
      item.descriptor <= req.descriptor;
      item.buf_addr   <= req.buf_addr;
      item.req_count  <= req.req_count;
      item.stack_top  <= req.stack_top;
      item.rx_char    <= req.rx_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (req.valid && req.ready) begin
      ivalid <= 1'b1;
    end else if (move) begin
      ivalid <= 1'b0;
    end
  end

endmodule
